// ===== rtl/core/sce_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table for the sine/cosine encoder
// angle and radius block. No dependencies.
package sce_pkg;

    // default parameter values
    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int ROTATION_STAGES_DEF = 16;

    // stream field widths
    localparam int FIELD_W = 16;
    localparam int ANGLE_W = 16;
    localparam int ROOT_W  = 16;

    // configuration port
    localparam int GAIN_W     = 15;
    localparam int OFFSET_W   = 13;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_ADDR_W = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_GAIN_COS   = 2'd0,
        CFG_GAIN_SIN   = 2'd1,
        CFG_OFFSET_COS = 2'd2,
        CFG_OFFSET_SIN = 2'd3
    } t_cfg_reg;

    localparam logic [GAIN_W-1:0]          GAIN_COS_RST   = 15'd16377;
    localparam logic [GAIN_W-1:0]          GAIN_SIN_RST   = 15'd16368;
    localparam logic signed [OFFSET_W-1:0] OFFSET_COS_RST = -13'sd33;
    localparam logic signed [OFFSET_W-1:0] OFFSET_SIN_RST = -13'sd33;

    // calibration set handed to the correction stage
    typedef struct packed {
        logic [GAIN_W-1:0]          gain_cos;
        logic [GAIN_W-1:0]          gain_sin;
        logic signed [OFFSET_W-1:0] offset_cos;
        logic signed [OFFSET_W-1:0] offset_sin;
    } t_cal_cfg;

    // angle accumulator, units of 1e-9 degree
    localparam int Z_W = 40;
    localparam logic signed [Z_W-1:0] NDEG_HALF_TURN     = 40'sd180000000000;
    localparam logic signed [Z_W-1:0] NDEG_FULL_TURN     = 40'sd360000000000;
    localparam logic signed [Z_W-1:0] NDEG_PER_CENTIDEG  = 40'sd10000000;
    localparam logic signed [Z_W-1:0] NDEG_HALF_CENTIDEG = 40'sd5000000;
    localparam logic [ANGLE_W-1:0]    CENTIDEG_FULL_TURN = 16'd36000;

    // atan(2^-i) in 1e-9 degree, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_ndeg(input int i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:       v = 40'sd45000000000;
            1:       v = 40'sd26565051177;
            2:       v = 40'sd14036243468;
            3:       v = 40'sd7125016349;
            4:       v = 40'sd3576334375;
            5:       v = 40'sd1789910608;
            6:       v = 40'sd895173710;
            7:       v = 40'sd447614171;
            8:       v = 40'sd223810500;
            9:       v = 40'sd111905677;
            10:      v = 40'sd55952892;
            11:      v = 40'sd27976453;
            12:      v = 40'sd13988227;
            13:      v = 40'sd6994114;
            14:      v = 40'sd3497057;
            15:      v = 40'sd1748528;
            16:      v = 40'sd874264;
            17:      v = 40'sd437132;
            18:      v = 40'sd218566;
            19:      v = 40'sd109283;
            20:      v = 40'sd54642;
            21:      v = 40'sd27321;
            22:      v = 40'sd13660;
            23:      v = 40'sd6830;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/sce_corr.sv =====
`timescale 1ns / 1ps
// Gain and offset correction of one cosine/sine sample pair, two register stages.
// Depends on sce_pkg.
module sce_corr #(
    parameter int SAMPLE_BITS = sce_pkg::SAMPLE_BITS_DEF,
    parameter int CORR_W      = SAMPLE_BITS + 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  sce_pkg::t_cal_cfg               i_cfg,
    input  logic                            i_valid,
    input  logic [sce_pkg::FIELD_W-1:0]     i_cos_sample,
    input  logic [sce_pkg::FIELD_W-1:0]     i_sin_sample,
    output logic                            o_valid,
    output logic signed [CORR_W-1:0]        o_cos,
    output logic signed [CORR_W-1:0]        o_sin
);

    localparam int RAW_W  = (SAMPLE_BITS > sce_pkg::FIELD_W) ? SAMPLE_BITS : sce_pkg::FIELD_W;
    localparam int PROD_W = SAMPLE_BITS + sce_pkg::GAIN_W + 1;

    logic [RAW_W-1:0]              raw_cos, raw_sin;
    logic signed [SAMPLE_BITS-1:0] smp_cos, smp_sin;
    logic signed [sce_pkg::GAIN_W:0] gain_cos, gain_sin;
    logic signed [PROD_W-1:0]      r_prod_cos, r_prod_sin;
    logic                          r_vld1, r_vld2;
    logic signed [CORR_W-1:0]      n_cos, n_sin, r_cos, r_sin;

    // low SAMPLE_BITS of each field as two's complement
    assign raw_cos  = RAW_W'(i_cos_sample);
    assign raw_sin  = RAW_W'(i_sin_sample);
    assign smp_cos  = raw_cos[SAMPLE_BITS-1:0];
    assign smp_sin  = raw_sin[SAMPLE_BITS-1:0];
    assign gain_cos = {1'b0, i_cfg.gain_cos};
    assign gain_sin = {1'b0, i_cfg.gain_sin};

    // stage 1: gain multiply
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_cos <= smp_cos * gain_cos;
            r_prod_sin <= smp_sin * gain_sin;
        end
    end

    // stage 2: Q1.14 round half up, then offset
    always_comb begin
        n_cos = CORR_W'((r_prod_cos + PROD_W'(8192)) >>> 14) + CORR_W'(i_cfg.offset_cos);
        n_sin = CORR_W'((r_prod_sin + PROD_W'(8192)) >>> 14) + CORR_W'(i_cfg.offset_sin);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= n_cos;
            r_sin <= n_sin;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
        end
    end

    assign o_valid = r_vld2;
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;

endmodule

// ===== rtl/core/sce_mag.sv =====
`timescale 1ns / 1ps
// Vector magnitude: squares, saturation check, one root bit per stage, rounding.
// Depends on sce_pkg.
module sce_mag #(
    parameter int CORR_W = sce_pkg::SAMPLE_BITS_DEF + 2
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [CORR_W-1:0]       i_cos,
    input  logic signed [CORR_W-1:0]       i_sin,
    output logic [sce_pkg::ROOT_W-1:0]     o_magnitude
);

    localparam int RW    = sce_pkg::ROOT_W;
    localparam int V_W   = 2 * RW;
    localparam int SQ_W  = (2 * CORR_W > V_W + 1) ? 2 * CORR_W : V_W + 1;
    // above 65535 * 65536 the rounded root is at least 65536
    localparam logic [SQ_W-1:0] SAT_LIM = SQ_W'(64'hFFFF_0000);

    logic signed [2*CORR_W-1:0] r_cc, r_ss;
    logic [SQ_W-1:0]            sum_sq;
    logic [V_W-1:0]             r_rem  [0:RW];
    logic [RW-1:0]              r_root [0:RW];
    logic                       r_sat  [0:RW];
    logic [RW-1:0]              r_mag;

    // squares
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cc <= i_cos * i_cos;
            r_ss <= i_sin * i_sin;
        end
    end

    // sum and saturation flag
    assign sum_sq = SQ_W'(unsigned'(r_cc)) + SQ_W'(unsigned'(r_ss));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= sum_sq[V_W-1:0];
            r_root[0] <= '0;
            r_sat[0]  <= (sum_sq > SAT_LIM);
        end
    end

    // restoring square root, bit RW-1-j decided in stage j
    for (genvar j = 0; j < RW; j++) begin : g_root
        localparam int K = RW - 1 - j;
        logic [V_W+1:0] trial;
        logic           fits;

        assign trial = ((V_W+2)'(r_root[j]) << (K + 1)) + ((V_W+2)'(1) << (2 * K));
        assign fits  = ((V_W+2)'(r_rem[j]) >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1]  <= fits ? (r_rem[j] - trial[V_W-1:0]) : r_rem[j];
                r_root[j+1] <= fits ? (r_root[j] | (RW'(1) << K)) : r_root[j];
                r_sat[j+1]  <= r_sat[j];
            end
        end
    end

    // round to nearest; remainder above the root means the upper half
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_sat[RW]) begin
                r_mag <= '1;
            end else if (r_rem[RW] > V_W'(r_root[RW])) begin
                r_mag <= r_root[RW] + RW'(1);
            end else begin
                r_mag <= r_root[RW];
            end
        end
    end

    assign o_magnitude = r_mag;

endmodule

// ===== rtl/core/sce_cordic.sv =====
`timescale 1ns / 1ps
// Vectoring rotation pipeline: half-turn pre-rotation, then one micro-rotation per
// stage with the angle accumulated in 1e-9 degree. Depends on sce_pkg.
module sce_cordic #(
    parameter int CORR_W          = sce_pkg::SAMPLE_BITS_DEF + 2,
    parameter int ROTATION_STAGES = sce_pkg::ROTATION_STAGES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [CORR_W-1:0]          i_cos,
    input  logic signed [CORR_W-1:0]          i_sin,
    output logic                              o_valid,
    output logic                              o_zero,
    output logic signed [sce_pkg::Z_W-1:0]    o_z
);

    localparam int N   = ROTATION_STAGES;
    localparam int X_W = CORR_W + 18;
    localparam int ZW  = sce_pkg::Z_W;

    logic signed [X_W-1:0] xs, ys;
    logic signed [X_W-1:0] r_x [0:N];
    logic signed [X_W-1:0] r_y [0:N];
    logic signed [ZW-1:0]  r_z [0:N];
    logic                  r_vld  [0:N];
    logic                  r_zero [0:N];

    assign xs = X_W'(i_cos) <<< 16;
    assign ys = X_W'(i_sin) <<< 16;

    // pre-rotation into the right half plane
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_cos < 0) begin
                r_x[0] <= -xs;
                r_y[0] <= -ys;
                r_z[0] <= sce_pkg::NDEG_HALF_TURN;
            end else begin
                r_x[0] <= xs;
                r_y[0] <= ys;
                r_z[0] <= '0;
            end
            r_zero[0] <= (i_cos == '0) && (i_sin == '0);
        end
    end

    // micro-rotations toward the x axis
    for (genvar i = 0; i < N; i++) begin : g_rot
        localparam logic signed [ZW-1:0] ATAN_I = sce_pkg::atan_ndeg(i);
        logic signed [X_W-1:0] dx, dy;

        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[i] >= 0) begin
                    r_x[i+1] <= r_x[i] + dx;
                    r_y[i+1] <= r_y[i] - dy;
                    r_z[i+1] <= r_z[i] + ATAN_I;
                end else begin
                    r_x[i+1] <= r_x[i] - dx;
                    r_y[i+1] <= r_y[i] + dy;
                    r_z[i+1] <= r_z[i] - ATAN_I;
                end
                r_zero[i+1] <= r_zero[i];
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= N; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 0; k < N; k++) begin
                r_vld[k+1] <= r_vld[k];
            end
        end
    end

    assign o_valid = r_vld[N];
    assign o_zero  = r_zero[N];
    assign o_z     = r_z[N];

endmodule

// ===== rtl/core/sce_cdiv.sv =====
`timescale 1ns / 1ps
// Angle wrap and conversion from 1e-9 degree to rounded hundredths of a degree,
// by a shift and a reciprocal multiplication over three stages. Depends on sce_pkg.
module sce_cdiv (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic                              i_zero,
    input  logic signed [sce_pkg::Z_W-1:0]    i_z,
    output logic                              o_valid,
    output logic [sce_pkg::ANGLE_W-1:0]       o_angle_centideg
);

    localparam int QW = sce_pkg::ANGLE_W;
    localparam int ZW = sce_pkg::Z_W;
    localparam int NW = 32;
    // 1e7 = 2^7 * 78125: drop seven bits, then multiply by 2^48 / 78125 rounded up,
    // which is exact for every 32-bit numerator
    localparam int              PRE_SHIFT  = 7;
    localparam int              POST_SHIFT = 48;
    localparam logic [NW-1:0]   RECIP      = 32'd3602879702;
    localparam logic signed [ZW-1:0] WRAP_RND =
        sce_pkg::NDEG_FULL_TURN + sce_pkg::NDEG_HALF_CENTIDEG;

    logic signed [ZW-1:0] z_rnd;
    logic [NW-1:0]        r_num;
    logic [2*NW-1:0]      r_prod;
    logic [QW-1:0]        quo;
    logic                 r_zero [0:1];
    logic                 r_vld  [0:2];
    logic [QW-1:0]        r_angle;

    // wrap into one turn and add half a step, one adder
    assign z_rnd = i_z + ((i_z < 0) ? WRAP_RND : sce_pkg::NDEG_HALF_CENTIDEG);

    // stage 1: numerator in units of 128e-9 degree
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num     <= z_rnd[PRE_SHIFT +: NW];
            r_zero[0] <= i_zero;
        end
    end

    // stage 2: reciprocal multiply
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod    <= r_num * RECIP;
            r_zero[1] <= r_zero[0];
        end
    end

    assign quo = r_prod[POST_SHIFT +: QW];

    // stage 3: full turn reads as zero; so does a zero vector
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_zero[1] || (quo == sce_pkg::CENTIDEG_FULL_TURN)) begin
                r_angle <= '0;
            end else begin
                r_angle <= quo;
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= 2; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            r_vld[1] <= r_vld[0];
            r_vld[2] <= r_vld[1];
        end
    end

    assign o_valid          = r_vld[2];
    assign o_angle_centideg = r_angle;

endmodule

// ===== rtl/core/sincos_encoder_angle_radius_top.sv =====
`timescale 1ns / 1ps
// Sine/cosine encoder interpolation: one angle and magnitude per sample pair.
// Instantiates sce_corr, sce_mag, sce_cordic and sce_cdiv; depends on sce_pkg.
//
// Each sample pair is gain- and offset-corrected, then turned into an angle in
// hundredths of a degree (0..35999) by a pipelined vectoring rotation unit, and
// into the rounded vector length (saturating at 65535) by a bit-per-stage square
// root. A new pair is taken every clock cycle while input ready is high; a result
// passes through the two correction stages, the longer of the angle path
// (ROTATION_STAGES + 1 rotation stages and 3 conversion stages) and the 19-stage
// root path, one register that lines both up, and the output register.
// The pipeline advances as a whole; a two-entry output buffer lets it run on
// while the downstream side stalls for one transaction, and input ready drops
// only once both entries hold results. A zero vector reports angle 0.
// Configuration writes take effect at once and are meant for idle periods.
module sincos_encoder_angle_radius_top #(
    parameter int SAMPLE_BITS     = sce_pkg::SAMPLE_BITS_DEF,
    parameter int ROTATION_STAGES = sce_pkg::ROTATION_STAGES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [31:0]                        i_s_axis_tdata,  // [15:0] cos_sample, [31:16] sin_sample
    // output stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [31:0]                        o_m_axis_tdata,  // [15:0] angle_centideg, [31:16] magnitude
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic [sce_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [sce_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int CORR_W = SAMPLE_BITS + 2;
    localparam int FW     = sce_pkg::FIELD_W;
    localparam int RW     = sce_pkg::ROOT_W;
    localparam int OUT_W  = sce_pkg::ANGLE_W + RW;
    // squares, sum, one stage per root bit, rounding
    localparam int MAG_LAT   = RW + 3;
    // pre-rotation, micro-rotations, three conversion stages
    localparam int ANG_LAT   = ROTATION_STAGES + 4;
    localparam int ALIGN_LAT = ((ANG_LAT > MAG_LAT) ? ANG_LAT : MAG_LAT) + 1;
    localparam int MAG_DLY   = ALIGN_LAT - MAG_LAT;
    localparam int ANG_DLY   = ALIGN_LAT - ANG_LAT;

    sce_pkg::t_cal_cfg               r_cfg;
    logic                            pipe_en;
    logic                            corr_valid;
    logic signed [CORR_W-1:0]        corr_cos, corr_sin;
    logic [RW-1:0]                   mag;
    logic [RW-1:0]                   r_mag_dly [0:MAG_DLY-1];
    logic                            rot_valid, rot_zero;
    logic signed [sce_pkg::Z_W-1:0]  rot_z;
    logic                            ang_valid;
    logic [sce_pkg::ANGLE_W-1:0]     ang;
    logic [sce_pkg::ANGLE_W-1:0]     r_ang_dly [0:ANG_DLY-1];
    logic                            r_ang_vld_dly [0:ANG_DLY-1];
    logic                            leave_valid;
    logic [OUT_W-1:0]                leave_data;
    logic                            out_take;
    logic                            r_out_valid, r_skid_valid;
    logic [OUT_W-1:0]                r_out_data, r_skid_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_cos   <= sce_pkg::GAIN_COS_RST;
            r_cfg.gain_sin   <= sce_pkg::GAIN_SIN_RST;
            r_cfg.offset_cos <= sce_pkg::OFFSET_COS_RST;
            r_cfg.offset_sin <= sce_pkg::OFFSET_SIN_RST;
        end else if (i_cfg_we) begin
            case (sce_pkg::t_cfg_reg'(i_cfg_addr))
                sce_pkg::CFG_GAIN_COS:   r_cfg.gain_cos   <= i_cfg_wdata;
                sce_pkg::CFG_GAIN_SIN:   r_cfg.gain_sin   <= i_cfg_wdata;
                sce_pkg::CFG_OFFSET_COS: r_cfg.offset_cos <= i_cfg_wdata[sce_pkg::OFFSET_W-1:0];
                sce_pkg::CFG_OFFSET_SIN: r_cfg.offset_sin <= i_cfg_wdata[sce_pkg::OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline moves while the skid entry is free
    assign pipe_en         = ~r_skid_valid;
    assign o_s_axis_tready = pipe_en;

    sce_corr #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CORR_W      (CORR_W)
    ) u_corr (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (pipe_en),
        .i_cfg        (r_cfg),
        .i_valid      (i_s_axis_tvalid),
        .i_cos_sample (i_s_axis_tdata[FW-1:0]),
        .i_sin_sample (i_s_axis_tdata[2*FW-1:FW]),
        .o_valid      (corr_valid),
        .o_cos        (corr_cos),
        .o_sin        (corr_sin)
    );

    sce_mag #(
        .CORR_W (CORR_W)
    ) u_mag (
        .i_clk       (i_clk),
        .i_en        (pipe_en),
        .i_cos       (corr_cos),
        .i_sin       (corr_sin),
        .o_magnitude (mag)
    );

    sce_cordic #(
        .CORR_W          (CORR_W),
        .ROTATION_STAGES (ROTATION_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (corr_valid),
        .i_cos   (corr_cos),
        .i_sin   (corr_sin),
        .o_valid (rot_valid),
        .o_zero  (rot_zero),
        .o_z     (rot_z)
    );

    sce_cdiv u_cdiv (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (pipe_en),
        .i_valid          (rot_valid),
        .i_zero           (rot_zero),
        .i_z              (rot_z),
        .o_valid          (ang_valid),
        .o_angle_centideg (ang)
    );

    // line both paths up; each gets at least one register
    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_mag_dly[0] <= mag;
            for (int k = 1; k < MAG_DLY; k++) begin
                r_mag_dly[k] <= r_mag_dly[k-1];
            end
            r_ang_dly[0] <= ang;
            for (int k = 1; k < ANG_DLY; k++) begin
                r_ang_dly[k] <= r_ang_dly[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ANG_DLY; k++) begin
                r_ang_vld_dly[k] <= 1'b0;
            end
        end else if (pipe_en) begin
            r_ang_vld_dly[0] <= ang_valid;
            for (int k = 1; k < ANG_DLY; k++) begin
                r_ang_vld_dly[k] <= r_ang_vld_dly[k-1];
            end
        end
    end

    assign leave_valid = r_ang_vld_dly[ANG_DLY-1];
    assign leave_data  = {r_mag_dly[MAG_DLY-1], r_ang_dly[ANG_DLY-1]};
    assign out_take    = r_out_valid & i_m_axis_tready;

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || out_take) begin
            r_out_valid <= leave_valid;
            r_out_data  <= leave_data;
        end else if (leave_valid) begin
            r_skid_valid <= 1'b1;
            r_skid_data  <= leave_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== bench/sincos_encoder_angle_radius_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sincos_encoder_angle_radius_top: random and directed sample pairs,
// calibration changes between phases, results checked against an in-bench predictor.
// Depends on sce_pkg and the RTL of the block; needs nothing else.
module sincos_encoder_angle_radius_top_tb;
    import sce_pkg::*;

    localparam int SAMPLE_BITS     = 16;
    localparam int ROTATION_STAGES = 16;
    localparam int DIRECTED_PHASES = 5;
    localparam int RANDOM_PHASES   = 8;
    localparam int PAIRS_PER_PHASE = 105;
    localparam int LONG_HOLD       = 300;
    localparam int DRAIN_CYCLES    = 60;

    // angles in units of 1e-9 degree
    localparam longint TURN_HALF_NDEG = 64'sd180000000000;
    localparam longint TURN_FULL_NDEG = 64'sd360000000000;
    localparam longint CENTIDEG_NDEG  = 64'sd10000000;
    localparam longint ATAN_STEP_NDEG [0:23] = '{
        64'sd45000000000, 64'sd26565051177, 64'sd14036243468, 64'sd7125016349,
        64'sd3576334375,  64'sd1789910608,  64'sd895173710,   64'sd447614171,
        64'sd223810500,   64'sd111905677,   64'sd55952892,    64'sd27976453,
        64'sd13988227,    64'sd6994114,     64'sd3497057,     64'sd1748528,
        64'sd874264,      64'sd437132,      64'sd218566,      64'sd109283,
        64'sd54642,       64'sd27321,       64'sd13660,       64'sd6830
    };

    typedef struct {
        logic [ANGLE_W-1:0] angle;
        logic [ROOT_W-1:0]  magnitude;
    } angle_radius_t;

    // Predicts angle and radius per sample pair and checks results in order
    class angle_radius_ledger;
        logic [GAIN_W-1:0]          gain_c;
        logic [GAIN_W-1:0]          gain_s;
        logic signed [OFFSET_W-1:0] ofs_c;
        logic signed [OFFSET_W-1:0] ofs_s;
        angle_radius_t              pending_results[$];
        bit                         failed;

        function void load_defaults();
            gain_c = GAIN_COS_RST;
            gain_s = GAIN_SIN_RST;
            ofs_c  = OFFSET_COS_RST;
            ofs_s  = OFFSET_SIN_RST;
        endfunction

        function void write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_GAIN_COS:   gain_c = val[GAIN_W-1:0];
                CFG_GAIN_SIN:   gain_s = val[GAIN_W-1:0];
                CFG_OFFSET_COS: ofs_c  = val[OFFSET_W-1:0];
                CFG_OFFSET_SIN: ofs_s  = val[OFFSET_W-1:0];
                default: ;
            endcase
        endfunction

        // Q1.14 gain, round half up, then offset in counts
        function longint corrected(logic [FIELD_W-1:0] raw, logic [GAIN_W-1:0] gain,
                                   logic signed [OFFSET_W-1:0] ofs);
            logic signed [SAMPLE_BITS-1:0] smp;
            longint                        prod;
            smp  = raw[SAMPLE_BITS-1:0];
            prod = longint'(smp) * longint'({1'b0, gain}) + 64'sd8192;
            return (prod >>> 14) + longint'(ofs);
        endfunction

        // integer square root, rounded to nearest
        function longint unsigned rounded_root(longint unsigned v);
            longint unsigned root, probe, rest;
            root  = 0;
            rest  = v;
            probe = 64'h1 << 62;
            while (probe > rest)
                probe = probe >> 2;
            while (probe != 0) begin
                if (rest >= root + probe) begin
                    rest = rest - (root + probe);
                    root = (root >> 1) + probe;
                end else begin
                    root = root >> 1;
                end
                probe = probe >> 2;
            end
            if (v - root * root > root)
                root++;
            return root;
        endfunction

        // vectoring rotation, result wrapped and rounded to 0.01 degree
        function logic [ANGLE_W-1:0] vector_angle(longint c, longint s);
            longint x, y, z, dx, dy, cd;
            if (c == 0 && s == 0)
                return '0;
            x = c * 65536;
            y = s * 65536;
            z = 0;
            if (x < 0) begin
                x = -x;
                y = -y;
                z = TURN_HALF_NDEG;
            end
            for (int i = 0; i < ROTATION_STAGES && i < 24; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ATAN_STEP_NDEG[i];
                end else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ATAN_STEP_NDEG[i];
                end
            end
            while (z < 0)
                z = z + TURN_FULL_NDEG;
            while (z >= TURN_FULL_NDEG)
                z = z - TURN_FULL_NDEG;
            cd = (z + CENTIDEG_NDEG / 2) / CENTIDEG_NDEG;
            if (cd >= 36000)
                cd = 0;
            return cd[ANGLE_W-1:0];
        endfunction

        function void note_pair(logic [FIELD_W-1:0] cos_raw, logic [FIELD_W-1:0] sin_raw);
            longint          c, s;
            longint unsigned len;
            angle_radius_t   want;
            c   = corrected(cos_raw, gain_c, ofs_c);
            s   = corrected(sin_raw, gain_s, ofs_s);
            len = rounded_root(longint'(c * c + s * s));
            if (len > 65535)
                len = 65535;
            want.magnitude = len[ROOT_W-1:0];
            want.angle     = vector_angle(c, s);
            pending_results.push_back(want);
        endfunction

        function void check_result(logic [31:0] data);
            angle_radius_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected: angle %0d, magnitude %0d",
                         $time, data[15:0], data[31:16]);
                failed = 1'b1;
                return;
            end
            want = pending_results.pop_front();
            if (data[15:0] !== want.angle) begin
                $display("%0t: angle mismatch: expected %0d, actual %0d",
                         $time, want.angle, data[15:0]);
                failed = 1'b1;
            end
            if (data[31:16] !== want.magnitude) begin
                $display("%0t: magnitude mismatch: expected %0d, actual %0d",
                         $time, want.magnitude, data[31:16]);
                failed = 1'b1;
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [31:0]           i_s_axis_tdata;   // [15:0] cos_sample, [31:16] sin_sample
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [31:0]           o_m_axis_tdata;   // [15:0] angle_centideg, [31:16] magnitude
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    angle_radius_ledger ledger;
    bit                 src_idle;
    bit                 sink_idle;
    bit                 hold_req;
    int                 hold_left;
    int                 stall_left;

    sincos_encoder_angle_radius_top #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .ROTATION_STAGES (ROTATION_STAGES)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Safety net against a hung handshake
    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: check each transaction, then decide next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready)
            ledger.check_result(o_m_axis_tdata);
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (sink_idle && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Offer one pair and wait for its transaction
    task automatic send_pair(logic [FIELD_W-1:0] cos_raw, logic [FIELD_W-1:0] sin_raw);
        if (src_idle && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {sin_raw, cos_raw};
        forever begin
            @(posedge i_clk);
            if (o_s_axis_tready)
                break;
        end
        ledger.note_pair(cos_raw, sin_raw);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (ledger.outstanding() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        ledger.write_reg(idx, val);
    endtask

    // New calibration, only once the pipeline has emptied
    task automatic calibrate(logic [GAIN_W-1:0] gc, logic [GAIN_W-1:0] gs,
                             logic [OFFSET_W-1:0] oc, logic [OFFSET_W-1:0] os);
        drain();
        write_reg(CFG_GAIN_COS, {1'b0, gc});
        write_reg(CFG_GAIN_SIN, {1'b0, gs});
        write_reg(CFG_OFFSET_COS, {2'b00, oc});
        write_reg(CFG_OFFSET_SIN, {2'b00, os});
        i_cfg_we <= 1'b0;
    endtask

    // Mix of full-range, near-zero, diagonal and near-axis pairs
    task automatic send_random_pair();
        logic [FIELD_W-1:0] c, s;
        int                 kind;
        kind = $urandom_range(0, 9);
        c    = FIELD_W'($urandom);
        s    = FIELD_W'($urandom);
        if (kind inside {6, 7}) begin
            c = FIELD_W'($urandom_range(0, 160)) - FIELD_W'(80);
            s = FIELD_W'($urandom_range(0, 160)) - FIELD_W'(80);
        end else if (kind == 8) begin
            s = $urandom_range(0, 1) ? c : -c;
        end else if (kind == 9) begin
            if ($urandom_range(0, 1))
                s = FIELD_W'($urandom_range(0, 80)) - FIELD_W'(40);
            else
                c = FIELD_W'($urandom_range(0, 80)) - FIELD_W'(40);
        end
        send_pair(c, s);
    endtask

    task automatic pick_idling(bit allowed);
        int mode;
        mode      = allowed ? $urandom_range(0, 3) : 0;
        src_idle  = mode[0];
        sink_idle = mode[1];
    endtask

    initial begin
        logic [GAIN_W-1:0]   gc, gs;
        logic [OFFSET_W-1:0] oc, os;
        ledger = new;
        ledger.load_defaults();
        src_idle        = 1'b0;
        sink_idle       = 1'b0;
        hold_req        = 1'b0;
        hold_left       = 0;
        stall_left      = 0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_m_axis_tready <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_addr      <= CFG_GAIN_COS;
        i_cfg_wdata     <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset calibration: field extremes and the offset-cancelled zero vector
        pick_idling(1'b1);
        send_pair(16'h0000, 16'h0000);
        send_pair(16'd33, 16'd33);
        send_pair(16'h7FFF, 16'h7FFF);
        send_pair(16'h8000, 16'h8000);
        send_pair(16'h7FFF, 16'h8000);
        send_pair(16'h8000, 16'h7FFF);
        send_pair(16'h5555, 16'hAAAA);
        send_pair(16'hAAAA, 16'h5555);

        // Unity gain, no offset: axes, quadrants, wrap just below a full turn
        calibrate(15'd16384, 15'd16384, 13'd0, 13'd0);
        pick_idling(1'b1);
        send_pair(16'h0000, 16'h0000);
        send_pair(16'd1, 16'h0000);
        send_pair(16'h0000, 16'd1);
        send_pair(16'hFFFF, 16'h0000);
        send_pair(16'h0000, 16'hFFFF);
        send_pair(16'hFFFF, 16'hFFFF);
        send_pair(-16'sd100, 16'd100);
        send_pair(16'd10000, 16'hFFFF);

        // Highest gain and extreme offsets: radius saturates
        calibrate(15'h7FFF, 15'h7FFF, 13'h0FFF, 13'h1000);
        send_pair(16'h7FFF, 16'h7FFF);
        send_pair(16'h8000, 16'h8000);
        send_pair(16'h0000, 16'h0000);

        // Zero gain: only the offsets remain
        calibrate(15'd0, 15'd0, 13'h1000, 13'h0FFF);
        send_pair(16'd1234, -16'sd1234);
        send_pair(16'h8000, 16'h7FFF);
        calibrate(15'd0, 15'd0, 13'd0, 13'd0);
        send_pair(16'h7FFF, 16'h8000);

        // Random calibrations, each with a run of random pairs
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            gc = $urandom_range(0, 3) == 0 ? GAIN_W'($urandom_range(0, 32767))
                                           : GAIN_W'($urandom_range(12000, 20000));
            gs = $urandom_range(0, 3) == 0 ? GAIN_W'($urandom_range(0, 32767))
                                           : GAIN_W'($urandom_range(12000, 20000));
            oc = $urandom_range(0, 1) ? OFFSET_W'($urandom)
                                      : OFFSET_W'($urandom_range(0, 400)) - OFFSET_W'(200);
            os = $urandom_range(0, 1) ? OFFSET_W'($urandom)
                                      : OFFSET_W'($urandom_range(0, 400)) - OFFSET_W'(200);
            calibrate(gc, gs, oc, os);
            pick_idling(ph != RANDOM_PHASES - 1);
            for (int n = 0; n < PAIRS_PER_PHASE; n++) begin
                // one long downstream hold so the block backs up onto its input
                if (ph == 1 && n == 30)
                    hold_req = 1'b1;
                send_random_pair();
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!ledger.failed && ledger.outstanding() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
